// ----- design/ecghpn_pkg.sv -----
package ecghpn_pkg;

  // Channel count and fixed-point formats
  localparam int CHANNEL_COUNT   = 2;
  localparam int MAX_CHANNELS    = 2;
  localparam int COEF_FRAC_BITS  = 28;
  localparam int STATE_FRAC_BITS = 16;

  // Field and datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int WORD_W     = 32;
  localparam int ALPHA_W    = 31;
  localparam int DIFF_W     = WORD_W + 2;
  localparam int HP_SHIFT   = 31;
  localparam int HP_PROD_W  = WORD_W + DIFF_W;
  localparam int Y_W        = 48;
  localparam int SPLIT      = 24;
  localparam int PB_W       = 2 * WORD_W;
  localparam int AHI_W      = WORD_W + Y_W - SPLIT;
  localparam int ALO_W      = WORD_W + SPLIT + 1;
  localparam int FULL_W     = AHI_W + SPLIT + 1;
  localparam int ACC_W      = PB_W + 2;
  localparam int NARROW_W   = 16;
  localparam int LEAD_W     = 5;
  localparam int SHIFT_W    = 5;
  localparam int LANE_DEPTH = 5;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = PTR_W + 1;

  // Stream and configuration port widths
  localparam int IN_W       = 72;
  localparam int OUT_W      = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register values after reset
  localparam logic              RST_HP_EN    = 1'b1;
  localparam logic              RST_NOTCH_EN = 1'b1;
  localparam logic [ALPHA_W-1:0] RST_ALPHA   = 31'd2120833375;
  localparam logic signed [WORD_W-1:0] RST_B1 = -32'sd165902239;
  localparam logic signed [WORD_W-1:0] RST_A1 = -32'sd157607127;
  localparam logic signed [WORD_W-1:0] RST_A2 = 32'sd242262999;
  localparam logic [SHIFT_W-1:0] RST_SHIFT   = 5'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_EN    = 3'd0,
    REG_NOTCH_EN = 3'd1,
    REG_ALPHA    = 3'd2,
    REG_B1       = 3'd3,
    REG_A1       = 3'd4,
    REG_A2       = 3'd5,
    REG_SHIFT    = 3'd6
  } cfg_reg_e;

  // Filter settings shared by all lanes
  typedef struct packed {
    logic                     hp_en;
    logic                     notch_en;
    logic [ALPHA_W-1:0]       alpha;
    logic signed [WORD_W-1:0] b1;
    logic signed [WORD_W-1:0] a1;
    logic signed [WORD_W-1:0] a2;
  } cfg_t;

  // Lane occupancy seen by the input flow control
  typedef struct packed {
    logic       busy;
    logic [1:0] inflight;
  } lane_stat_t;

  // One result word, first field in the lowest bits
  typedef struct packed {
    logic [LEAD_W-1:0]          lead_off;
    logic signed [NARROW_W-1:0] second_narrow;
    logic signed [NARROW_W-1:0] first_narrow;
    logic signed [SAMPLE_W-1:0] second_filtered;
    logic signed [SAMPLE_W-1:0] first_filtered;
  } out_word_t;

endpackage

// ----- design/ecghpn_lane.sv -----
module ecghpn_lane
  import ecghpn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     start,
  input  logic [SAMPLE_W-1:0]      sample,
  output lane_stat_t               stat,
  output logic                     res_valid,
  output logic signed [WORD_W-1:0] res_value
);

  localparam int F = STATE_FRAC_BITS;
  localparam int C = COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (Y_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(1) <<< (Y_W - 1));
  localparam logic signed [Y_W:0] ROUND_HALF = (Y_W + 1)'(1) <<< (F - 1);

  // Stage valid flags
  logic v0, v1, v2, v3, v4;

  // Filter state
  logic signed [WORD_W-1:0] hp_last_in, hp_last_out;
  logic signed [WORD_W-1:0] nd_x1, nd_x2;
  logic signed [Y_W-1:0]    nd_y1, nd_y2;

  // Stage payloads
  logic signed [WORD_W-1:0]    r0_x, r1_x, r2_v, r3_v, r4_v;
  logic signed [DIFF_W-1:0]    r0_diff;
  logic signed [HP_PROD_W-1:0] r1_php;
  logic signed [PB_W-1:0]      r1_pb1;
  logic signed [AHI_W-1:0]     r1_a1hi, r1_a2hi;
  logic signed [ALO_W-1:0]     r1_a1lo, r1_a2lo;
  logic signed [ACC_W-1:0]     r2_t2, r2_t4, r2_t5;
  logic signed [Y_W-1:0]       r3_acc;

  logic signed [WORD_W-1:0] x_in, hp_y, notch_v;
  logic signed [WORD_W-1:0] alpha_s;
  logic signed [FULL_W-1:0] a1_full, a2_full;
  logic signed [ACC_W-1:0]  acc_sum, acc_sat;

  // Round to nearest with ties away from zero, then clamp to 24 bits
  function automatic logic signed [WORD_W-1:0] round_sat(input logic signed [Y_W-1:0] acc);
    logic signed [Y_W:0] ext;
    logic signed [Y_W:0] mag;
    logic signed [Y_W:0] q;
    ext = (Y_W + 1)'(acc);
    mag = acc[Y_W-1] ? (-ext + ROUND_HALF) : (ext + ROUND_HALF);
    q   = mag >>> F;
    if (acc[Y_W-1]) q = -q;
    if (q > (Y_W + 1)'(8388607)) return WORD_W'(8388607);
    if (q < -(Y_W + 1)'(8388608)) return -WORD_W'(8388608);
    return WORD_W'(q);
  endfunction

  assign x_in    = WORD_W'($signed(sample));
  assign alpha_s = $signed({1'b0, cfg.alpha});
  assign hp_y    = $signed(r1_php[HP_SHIFT+WORD_W-1:HP_SHIFT]);

  // Rebuild the split coefficient products; the r2 stage scales them by the coefficient format
  assign a1_full = (FULL_W'(r1_a1hi) <<< SPLIT) + FULL_W'(r1_a1lo);
  assign a2_full = (FULL_W'(r1_a2hi) <<< SPLIT) + FULL_W'(r1_a2lo);

  // Notch accumulator with clamp to the state width
  assign acc_sum = (ACC_W'(r2_v) <<< F) + r2_t2 + (ACC_W'(nd_x2) <<< F) - r2_t4 - r2_t5;
  always_comb begin
    if (acc_sum > Y_MAX) begin
      acc_sat = Y_MAX;
    end else if (acc_sum < Y_MIN) begin
      acc_sat = Y_MIN;
    end else begin
      acc_sat = acc_sum;
    end
  end

  assign notch_v = round_sat(r3_acc);

  // Stage valid flags and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      hp_last_in  <= '0;
      hp_last_out <= '0;
      nd_x1 <= '0;
      nd_x2 <= '0;
      nd_y1 <= '0;
      nd_y2 <= '0;
    end else begin
      v0 <= start;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (v1 && cfg.hp_en) begin
        hp_last_in  <= r1_x;
        hp_last_out <= hp_y;
      end
      if (v2 && cfg.notch_en) begin
        nd_x2 <= nd_x1;
        nd_x1 <= r2_v;
        nd_y2 <= nd_y1;
        nd_y1 <= acc_sat[Y_W-1:0];
      end
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    r0_x    <= x_in;
    r0_diff <= DIFF_W'(hp_last_out) + DIFF_W'(x_in) - DIFF_W'(hp_last_in);

    r1_x    <= r0_x;
    r1_php  <= HP_PROD_W'(alpha_s) * HP_PROD_W'(r0_diff);
    r1_pb1  <= PB_W'(cfg.b1) * PB_W'(nd_x1);
    r1_a1hi <= AHI_W'(cfg.a1) * AHI_W'($signed(nd_y1[Y_W-1:SPLIT]));
    r1_a1lo <= ALO_W'(cfg.a1) * ALO_W'($signed({1'b0, nd_y1[SPLIT-1:0]}));
    r1_a2hi <= AHI_W'(cfg.a2) * AHI_W'($signed(nd_y2[Y_W-1:SPLIT]));
    r1_a2lo <= ALO_W'(cfg.a2) * ALO_W'($signed({1'b0, nd_y2[SPLIT-1:0]}));

    r2_v  <= cfg.hp_en ? hp_y : r1_x;
    r2_t2 <= ACC_W'(r1_pb1 >>> (C - F));
    r2_t4 <= ACC_W'(a1_full >>> C);
    r2_t5 <= ACC_W'(a2_full >>> C);

    r3_acc <= acc_sat[Y_W-1:0];
    r3_v   <= r2_v;

    r4_v <= cfg.notch_en ? notch_v : r3_v;
  end

  // The lane is busy while a sample holds stage v0 or v1, before its state loop closes
  assign stat.busy     = v0 | v1;
  assign stat.inflight = 2'(v2) + 2'(v3) + 2'(v4);
  assign res_valid     = v4;
  assign res_value     = r4_v;

endmodule

// ----- design/ecghpn_merge.sv -----
module ecghpn_merge
  import ecghpn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     res_valid,
  input  logic signed [WORD_W-1:0] res_value [MAX_CHANNELS],
  input  logic [LEAD_W-1:0]        lead_off,
  input  logic [SHIFT_W-1:0]       output_shift,
  input  logic                     pop,
  output logic                     out_valid,
  output out_word_t                out_word,
  output logic [LEVEL_W-1:0]       level
);

  out_word_t          queue [FIFO_DEPTH];
  out_word_t          word_in;
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic               do_pop;
  logic signed [SAMPLE_W-1:0] filt [MAX_CHANNELS];
  logic signed [NARROW_W-1:0] narr [MAX_CHANNELS];

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [WORD_W-1:0] v);
    if (v > WORD_W'(8388607)) return SAMPLE_W'(8388607);
    if (v < -WORD_W'(8388608)) return -SAMPLE_W'(8388608);
    return SAMPLE_W'(v);
  endfunction

  function automatic logic signed [NARROW_W-1:0] sat16(input logic signed [WORD_W-1:0] v);
    if (v > WORD_W'(32767)) return NARROW_W'(32767);
    if (v < -WORD_W'(32768)) return -NARROW_W'(32768);
    return NARROW_W'(v);
  endfunction

  // Clamp each lane's value and its shifted copy
  always_comb begin
    for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
      filt[ch] = sat24(res_value[ch]);
      narr[ch] = sat16(res_value[ch] >>> output_shift);
    end
  end

  assign word_in.lead_off        = lead_off;
  assign word_in.first_filtered  = filt[0];
  assign word_in.second_filtered = filt[1];
  assign word_in.first_narrow    = narr[0];
  assign word_in.second_narrow   = narr[1];

  assign do_pop    = pop && (level != '0);
  assign out_valid = (level != '0);
  assign out_word  = queue[rd_ptr];

  // Result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (res_valid) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      level <= level + LEVEL_W'(res_valid) - LEVEL_W'(do_pop);
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (res_valid) queue[wr_ptr] <= word_in;
  end

endmodule

// ----- design/ecg_frame_highpass_notch.sv -----
// Two-channel ECG frame filter: DC-blocking high-pass and notch biquad per channel.
// Input words arrive on s_tvalid/s_tready/s_tdata, one front-end frame per word;
// each accepted word yields exactly one result word on m_tvalid/m_tready/m_tdata.
// Settings are written on cfg_valid/cfg_ready/cfg_index/cfg_data (always ready);
// indexes beyond the register list are ignored. Write settings only while idle.
// Each channel runs in its own lane; both lanes take the same frame in step.
// A result passes through the lane stages and the result queue before it is offered.
// A lane takes no new word until the last word has updated its filter state loop
// (the notch feedback products read the state written by the previous word).
// A four-word result queue parts the output from the lanes; s_tready drops while
// the queue and the words still inside the lanes would fill it, so a stalled
// receiver loses nothing and input resumes as soon as words are taken.
// Reset clears all filter state, empties the queue and restores the register
// defaults: both stages enabled, default coefficients and a shift of eight.
module ecg_frame_highpass_notch
  import ecghpn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // status_word [23:0], first_raw [47:24], second_raw [71:48]
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // first_filtered [23:0], second_filtered [47:24], first_narrow [63:48],
  // second_narrow [79:64], lead_off [84:80], zero fill [87:85]
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                     cfg;
  logic [SHIFT_W-1:0]       output_shift;
  logic                     accept;
  lane_stat_t               stat [MAX_CHANNELS];
  logic                     res_valid [MAX_CHANNELS];
  logic signed [WORD_W-1:0] res_value [MAX_CHANNELS];
  logic [SAMPLE_W-1:0]      sample [MAX_CHANNELS];
  logic [LEAD_W-1:0]        lead_pipe [LANE_DEPTH];
  logic [LEVEL_W-1:0]       level;
  out_word_t                out_word;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hp_en    <= RST_HP_EN;
      cfg.notch_en <= RST_NOTCH_EN;
      cfg.alpha    <= RST_ALPHA;
      cfg.b1       <= RST_B1;
      cfg.a1       <= RST_A1;
      cfg.a2       <= RST_A2;
      output_shift <= RST_SHIFT;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_HP_EN:    cfg.hp_en    <= cfg_data[0];
        REG_NOTCH_EN: cfg.notch_en <= cfg_data[0];
        REG_ALPHA:    cfg.alpha    <= cfg_data[ALPHA_W-1:0];
        REG_B1:       cfg.b1       <= $signed(cfg_data);
        REG_A1:       cfg.a1       <= $signed(cfg_data);
        REG_A2:       cfg.a2       <= $signed(cfg_data);
        REG_SHIFT:    output_shift <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Take a word when the lanes are free and the queue has a place for it
  assign s_tready = !stat[0].busy &&
                    ((LEVEL_W + 1)'(level) + (LEVEL_W + 1)'(stat[0].inflight) <
                     (LEVEL_W + 1)'(FIFO_DEPTH));
  assign accept = s_tvalid && s_tready;

  assign sample[0] = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign sample[1] = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

  // One lane per channel
  for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
    if (ch < CHANNEL_COUNT) begin : g_on
      ecghpn_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .cfg       (cfg),
        .start     (accept),
        .sample    (sample[ch]),
        .stat      (stat[ch]),
        .res_valid (res_valid[ch]),
        .res_value (res_value[ch])
      );
    end else begin : g_off
      assign stat[ch]      = '0;
      assign res_valid[ch] = 1'b0;
      assign res_value[ch] = '0;
    end
  end

  // Lead-off code travels alongside the lanes
  always_ff @(posedge clk) begin
    lead_pipe[0] <= {s_tdata[19:16], s_tdata[15]};
    for (int i = 1; i < LANE_DEPTH; i++) begin
      lead_pipe[i] <= lead_pipe[i-1];
    end
  end

  ecghpn_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid[0]),
    .res_value    (res_value),
    .lead_off     (lead_pipe[LANE_DEPTH-1]),
    .output_shift (output_shift),
    .pop          (m_tready),
    .out_valid    (m_tvalid),
    .out_word     (out_word),
    .level        (level)
  );

  assign m_tdata = {(OUT_W - $bits(out_word_t))'(0), out_word};

  // The queue never holds more words than it has places
  assert property (@(posedge clk) disable iff (rst) level <= LEVEL_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // Every accepted word reaches the queue after the fixed lane delay
  assert property (@(posedge clk) disable iff (rst) accept |-> ##5 res_valid[0])
    else $error("lane result missing");

  // A result only lands when the queue has room or a word is leaving
  assert property (@(posedge clk) disable iff (rst)
                   res_valid[0] |-> (level < LEVEL_W'(FIFO_DEPTH)) || m_tready)
    else $error("result arrived with the queue full");

endmodule

// ----- bench/ecg_frame_checker.sv -----
module ecg_frame_checker
  import ecghpn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // status_word [23:0], first_raw [47:24], second_raw [71:48]
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // first_filtered [23:0], second_filtered [47:24], first_narrow [63:48],
  // second_narrow [79:64], lead_off [84:80], zero fill [87:85]
  input  logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  // Wide enough for a coefficient times a 48-bit feedback value without loss.
  typedef logic signed [95:0] wide_t;

  localparam int     WORD_BITS = $bits(out_word_t);
  localparam longint ACC_MAX   = (longint'(1) <<< (Y_W - 1)) - 1;
  localparam longint ACC_MIN   = -(longint'(1) <<< (Y_W - 1));
  localparam longint HALF_LSB  = longint'(1) <<< (STATE_FRAC_BITS - 1);

  // Filter settings as last written on the configuration channel.
  logic                     hp_on;
  logic                     notch_on;
  logic [ALPHA_W-1:0]       hp_alpha;
  logic signed [WORD_W-1:0] coef_b1;
  logic signed [WORD_W-1:0] coef_a1;
  logic signed [WORD_W-1:0] coef_a2;
  logic [SHIFT_W-1:0]       narrow_shift;

  // Filter history per channel.
  int     hp_prev_in   [MAX_CHANNELS];
  int     hp_prev_out  [MAX_CHANNELS];
  int     notch_x1     [MAX_CHANNELS];
  int     notch_x2     [MAX_CHANNELS];
  longint notch_y1     [MAX_CHANNELS];
  longint notch_y2     [MAX_CHANNELS];

  // Result words predicted for accepted frames, oldest first.
  out_word_t predicted_words [$];

  initial mismatches = 0;
  initial outstanding = 0;

  // Prints one line for each problem and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One-pole DC blocker; the product is floored by 2^31 and wraps to 32 bits.
  function automatic int dc_block(input int ch, input int x);
    longint gain;
    longint diff;
    longint prod;
    int     y;
    gain = hp_alpha;
    diff = longint'(hp_prev_out[ch]) + longint'(x) - longint'(hp_prev_in[ch]);
    prod = gain * diff;
    y = int'(prod >>> HP_SHIFT);
    hp_prev_in[ch] = x;
    hp_prev_out[ch] = y;
    return y;
  endfunction

  // Notch biquad with unit outer taps; the feedback value keeps a 48-bit range.
  function automatic int notch_filter(input int ch, input int x);
    wide_t  acc;
    longint y;
    longint r;
    acc = (wide_t'(x) <<< STATE_FRAC_BITS)
        + ((wide_t'(coef_b1) * wide_t'(notch_x1[ch])) >>> (COEF_FRAC_BITS - STATE_FRAC_BITS))
        + (wide_t'(notch_x2[ch]) <<< STATE_FRAC_BITS)
        - ((wide_t'(coef_a1) * wide_t'(notch_y1[ch])) >>> COEF_FRAC_BITS)
        - ((wide_t'(coef_a2) * wide_t'(notch_y2[ch])) >>> COEF_FRAC_BITS);
    if (acc > wide_t'(ACC_MAX)) acc = wide_t'(ACC_MAX);
    if (acc < wide_t'(ACC_MIN)) acc = wide_t'(ACC_MIN);
    y = longint'(acc);
    notch_x2[ch] = notch_x1[ch];
    notch_x1[ch] = x;
    notch_y2[ch] = notch_y1[ch];
    notch_y1[ch] = y;
    // Round to nearest with ties away from zero.
    if (y >= 0) begin
      r = (y + HALF_LSB) >>> STATE_FRAC_BITS;
    end else begin
      r = -((-y + HALF_LSB) >>> STATE_FRAC_BITS);
    end
    return int'(clamp(r, -(longint'(1) <<< (SAMPLE_W - 1)), (longint'(1) <<< (SAMPLE_W - 1)) - 1));
  endfunction

  // Works out the result word for one frame and advances the filter history.
  function automatic out_word_t filter_frame(input logic [IN_W-1:0] frame);
    out_word_t            w;
    logic [SAMPLE_W-1:0]  raw;
    int                   v;
    int                   ch;
    longint               wide_out;
    longint               narrow_out;
    w = '0;
    for (ch = 0; ch < CHANNEL_COUNT; ch++) begin
      raw = frame[SAMPLE_W*(ch+1) +: SAMPLE_W];
      v = {{(WORD_W - SAMPLE_W){raw[SAMPLE_W-1]}}, raw};
      if (hp_on) v = dc_block(ch, v);
      if (notch_on) v = notch_filter(ch, v);
      wide_out = clamp(v, -(longint'(1) <<< (SAMPLE_W - 1)), (longint'(1) <<< (SAMPLE_W - 1)) - 1);
      narrow_out = clamp(v >>> narrow_shift, -(longint'(1) <<< (NARROW_W - 1)),
                         (longint'(1) <<< (NARROW_W - 1)) - 1);
      if (ch == 0) begin
        w.first_filtered = wide_out[SAMPLE_W-1:0];
        w.first_narrow   = narrow_out[NARROW_W-1:0];
      end else begin
        w.second_filtered = wide_out[SAMPLE_W-1:0];
        w.second_narrow   = narrow_out[NARROW_W-1:0];
      end
    end
    // Lead-off: status byte 0 low nibble above byte 1 bit 7.
    w.lead_off = {frame[19:16], frame[15]};
    return w;
  endfunction

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_HP_EN:    hp_on = d[0];
      REG_NOTCH_EN: notch_on = d[0];
      REG_ALPHA:    hp_alpha = d[ALPHA_W-1:0];
      REG_B1:       coef_b1 = d;
      REG_A1:       coef_a1 = d;
      REG_A2:       coef_a2 = d;
      REG_SHIFT:    narrow_shift = d[SHIFT_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic compare_word(input logic [OUT_W-1:0] raw_word, input out_word_t want);
    out_word_t got;
    got = out_word_t'(raw_word[WORD_BITS-1:0]);
    check_field("first_filtered", got.first_filtered, want.first_filtered);
    check_field("second_filtered", got.second_filtered, want.second_filtered);
    check_field("first_narrow", got.first_narrow, want.first_narrow);
    check_field("second_narrow", got.second_narrow, want.second_narrow);
    check_field("lead_off", got.lead_off, want.lead_off);
    check_field("zero fill", raw_word[OUT_W-1:WORD_BITS], 0);
  endtask

  // Follow every handshake on the three channels.
  always @(posedge clk) begin
    if (rst) begin
      hp_on = RST_HP_EN;
      notch_on = RST_NOTCH_EN;
      hp_alpha = RST_ALPHA;
      coef_b1 = RST_B1;
      coef_a1 = RST_A1;
      coef_a2 = RST_A2;
      narrow_shift = RST_SHIFT;
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
        hp_prev_in[ch] = 0;
        hp_prev_out[ch] = 0;
        notch_x1[ch] = 0;
        notch_x2[ch] = 0;
        notch_y1[ch] = 0;
        notch_y2[ch] = 0;
      end
      predicted_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predicted_words.push_back(filter_frame(s_tdata));
      if (m_tvalid && m_tready) begin
        if (predicted_words.size() == 0) begin
          report_mismatch($sformatf("result word %h with no frame outstanding", m_tdata));
        end else begin
          compare_word(m_tdata, predicted_words.pop_front());
        end
      end
    end
    outstanding = predicted_words.size();
  end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  import ecghpn_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 64;
  localparam int HOLD_AFTER    = 150;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_FRAMES  = 108;
  localparam int STEADY_PHASE  = 3;
  localparam int RUN_LIMIT     = 4_000_000;

  // An index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic [SAMPLE_W-1:0] S_MAX  = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] S_MIN  = 24'h800000;
  localparam logic [SAMPLE_W-1:0] S_ONES = 24'hFFFFFF;
  localparam logic [SAMPLE_W-1:0] S_ZERO = 24'h000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic steady = 1'b0;
  int   frames_sent = 0;
  int   mismatches;
  int   outstanding;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  ecg_frame_highpass_notch u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ecg_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Holds the configuration write valid until the block takes it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register, then the spare index, and releases the channel.
  task automatic write_settings(input logic [31:0] hp, input logic [31:0] nt,
                                input logic [31:0] alpha, input logic [31:0] b1,
                                input logic [31:0] a1, input logic [31:0] a2,
                                input logic [31:0] shift);
    write_reg(REG_HP_EN, hp);
    write_reg(REG_NOTCH_EN, nt);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_B1, b1);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_SHIFT, shift);
    write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Offers one frame word, after a random idle gap unless steady, and waits for it to be taken.
  task automatic send_frame(input logic [SAMPLE_W-1:0] status,
                            input logic [SAMPLE_W-1:0] first,
                            input logic [SAMPLE_W-1:0] second);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {second, first, status};
    do @(posedge clk); while (!s_tready);
    frames_sent++;
  endtask

  // Lets every outstanding result drain and the lanes fall quiet.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly small physiological swings, with full-range and rail values mixed in.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(4))
      0: return SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return S_ONES;
          default: return S_ZERO;
        endcase
      end
      default: return SAMPLE_W'($urandom_range(0, 8000) - 4000);
    endcase
  endfunction

  // A stable notch: random centre, pole radius between 0.75 and 0.97.
  function automatic void pick_notch(output logic [31:0] b1, output logic [31:0] a1,
                                     output logic [31:0] a2);
    int two_cos;
    int radius;
    two_cos = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
    radius = $urandom_range(24, 31);
    b1 = two_cos;
    a1 = int'((longint'(two_cos) * radius) >>> 5);
    a2 = (radius * radius) << 18;
  endfunction

  // The receiver stalls at random, once for a long stretch, never while steady.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && frames_sent >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    logic [31:0] hp_word;
    logic [31:0] nt_word;
    logic [31:0] alpha_word;
    logic [31:0] b1_word;
    logic [31:0] a1_word;
    logic [31:0] a2_word;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: rail samples and lead-off bit patterns.
    send_frame(24'h000000, S_ZERO, S_ZERO);
    send_frame(24'hFFFFFF, S_MAX, S_MIN);
    send_frame(24'h0F8000, S_MIN, S_MAX);
    send_frame(24'h0A0000, S_ONES, 24'h000001);
    send_frame(24'h058000, S_MAX, S_MAX);
    send_frame(24'hF07FFF, S_MIN, S_MIN);
    drain();

    // Both stages off with no shift: samples pass straight through, and the
    // narrow copy saturates just past the sixteen-bit range.
    write_settings(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFE0);
    send_frame(24'h123456, S_MAX, S_MIN);
    send_frame(24'h000000, 24'h000100, 24'hFFFF00);
    send_frame(24'hABCDEF, 24'h007FFF, 24'hFF8000);
    send_frame(24'h5A5A5A, 24'h008000, 24'hFF7FFF);
    drain();

    // Extreme coefficients drive the notch feedback into saturation; the
    // widest shift leaves only the sign in the narrow copy.
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) begin
      send_frame(SAMPLE_W'($urandom), S_MAX, S_MIN);
      send_frame(SAMPLE_W'($urandom), S_MIN, S_MAX);
    end
    drain();

    // A zero pole coefficient blanks the high-pass; most negative b1 and a2, zero a1.
    write_settings(32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000,
                   32'h0, 32'h8000_0000, 32'd16);
    send_frame(24'hFFFFFF, S_MAX, S_MIN);
    send_frame(24'h000000, S_MIN, S_MAX);
    send_frame(24'h0F0000, S_ONES, S_ZERO);
    send_frame(24'h008000, S_ZERO, S_ONES);
    drain();

    // Random phases, each under its own settings; every enable pairing occurs.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = (phase == STEADY_PHASE);
      if (phase == 0) begin
        write_settings(32'(RST_HP_EN), 32'(RST_NOTCH_EN), 32'(RST_ALPHA), RST_B1, RST_A1,
                       RST_A2, 32'(RST_SHIFT));
      end else begin
        hp_word = ($urandom & ~32'h1) | 32'(phase % 2);
        nt_word = ($urandom & ~32'h1) | 32'(((phase / 2) % 2) ^ 1);
        if (phase % 2 == 1) begin
          alpha_word = $urandom;
        end else begin
          alpha_word = 32'h7FFF_FFFF - $urandom_range(0, 32'h0400_0000);
        end
        if (phase == RANDOM_PHASES - 1) begin
          b1_word = $urandom;
          a1_word = $urandom;
          a2_word = $urandom;
        end else begin
          pick_notch(b1_word, a1_word, a2_word);
        end
        write_settings(hp_word, nt_word, alpha_word, b1_word, a1_word, a2_word, $urandom);
      end
      repeat (PHASE_FRAMES) send_frame(SAMPLE_W'($urandom), pick_sample(), pick_sample());
      drain();
    end
    steady = 1'b0;

    @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
